// File: rtl/hsl_to_rgb_converter_unit_macros.svh
// hsl_to_rgb_converter_unit_macros.svh: assertion macros for the HSL to RGB converter.
// No dependencies; the checker file includes it.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define HSL2RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HSL2RGB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/hsl2rgb_pkg.sv
// hsl2rgb_pkg: widths, constants and the stage-enable type of the HSL to RGB converter.
// No dependencies.
package hsl2rgb_pkg;

  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 14;  // helper values scaled by 10000
  localparam int unsigned NumW  = 20;  // channel numerator, up to 600000
  localparam int unsigned WgtW  = 6;   // hue distance inside a ramp, 0..60
  localparam int unsigned ProdW = 49;

  localparam logic [HueW-1:0] HueTurn = 9'd360;
  localparam logic [HueW-1:0] Hue60   = 9'd60;
  localparam logic [HueW-1:0] Hue120  = 9'd120;
  localparam logic [HueW-1:0] Hue180  = 9'd180;
  localparam logic [HueW-1:0] Hue240  = 9'd240;

  localparam logic [PctW-1:0] PctMax  = 7'd100;
  localparam logic [PctW-1:0] PctHalf = 7'd50;

  localparam logic [WgtW-1:0] SectorDeg = 6'd60;

  // floor(n*255/600000) = floor(n*17/40000) = (n * 17 * ceil(2^40/40000)) >> 40,
  // exact for every n up to 600000.
  localparam logic [28:0]     RecipK     = 29'd467292447;
  localparam int unsigned     RecipShift = 40;

  typedef struct packed {
    logic en_num;  // numerator stage advances
    logic en_out;  // output stage advances
  } hsl2rgb_stg_t;

endpackage

// File: rtl/hsl2rgb_chan.sv
// hsl2rgb_chan: one color channel, piecewise numerator and scaling to 8 bits, two stages.
// Depends on hsl2rgb_pkg.
module hsl2rgb_chan
  import hsl2rgb_pkg::*;
(
  input  logic                 clk_i,
  input  hsl2rgb_stg_t         stg_i,
  input  logic [HueW-1:0]      hue_i,
  input  logic [FracW-1:0]     p_i,
  input  logic [FracW-1:0]     q_i,
  input  logic [FracW-1:0]     d_i,
  output logic [ChanW-1:0]     chan_o
);

  logic [FracW-1:0] base;
  logic [WgtW-1:0]  wgt;
  logic [NumW-1:0]  num_d, num_q;
  logic [ProdW-1:0] scaled;
  logic [ChanW-1:0] chan_d, chan_q;

  // rising ramp, top plateau, falling ramp, bottom plateau
  always_comb begin
    priority if (hue_i < Hue60) begin
      base = p_i;
      wgt  = hue_i[WgtW-1:0];
    end else if (hue_i < Hue180) begin
      base = q_i;
      wgt  = '0;
    end else if (hue_i < Hue240) begin
      base = p_i;
      wgt  = WgtW'(Hue240 - hue_i);
    end else begin
      base = p_i;
      wgt  = '0;
    end
  end

  assign num_d = NumW'(base) * NumW'(SectorDeg) + NumW'(d_i) * NumW'(wgt);

  always_ff @(posedge clk_i) begin
    if (stg_i.en_num) begin
      num_q <= num_d;
    end
  end

  assign scaled = ProdW'(num_q) * ProdW'(RecipK);
  assign chan_d = scaled[RecipShift +: ChanW];

  always_ff @(posedge clk_i) begin
    if (stg_i.en_out) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// File: rtl/hsl_to_rgb_converter_unit.sv
// hsl_to_rgb_converter_unit: top level of the HSL to RGB converter, four-stage pipeline.
// Depends on hsl2rgb_pkg and hsl2rgb_chan.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | hue_degrees_i, saturation_pct_i,
//          |           |                         | lightness_pct_i
//  out     | source    | out_valid_o/out_ready_i | red_o, green_o, blue_o
//
// One request per cycle while the output is not stalled; an accepted request moves
// through the stage valid bits v1_q to v4_q, and v4_q drives out_valid_o.
// Stage 1 wraps and offsets the hue per channel and clamps percents, stage 2 forms the
// helper values q and p, stage 3 the per-channel numerator, stage 4 the reciprocal multiply to 8 bits.
// Reset clears only the stage valid bits; data registers are not reset.
// A stage advances whenever it is empty or the stage after it advances, so a stall on
// the output fills bubbles first and then holds every stage without loss or repeat.
module hsl_to_rgb_converter_unit
  import hsl2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [HueW-1:0]  hue_degrees_i,
  input  logic [PctW-1:0]  saturation_pct_i,
  input  logic [PctW-1:0]  lightness_pct_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: hue wrap, channel offsets, clamp ----------------
  logic [HueW-1:0] hue_mod;
  logic [HueW-1:0] hr1_d, hg1_d, hb1_d, hr1_q, hg1_q, hb1_q;
  logic [PctW-1:0] s1_d, l1_d, s1_q, l1_q;

  always_comb begin
    hue_mod = (hue_degrees_i >= HueTurn) ? hue_degrees_i - HueTurn : hue_degrees_i;
    hg1_d   = hue_mod;
    // red at +120, blue at +240, both mod 360
    hr1_d   = (hue_mod >= Hue240) ? hue_mod - Hue240 : hue_mod + Hue120;
    hb1_d   = (hue_mod >= Hue120) ? hue_mod - Hue120 : hue_mod + Hue240;
    s1_d    = (saturation_pct_i > PctMax) ? PctMax : saturation_pct_i;
    l1_d    = (lightness_pct_i > PctMax) ? PctMax : lightness_pct_i;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hr1_q <= hr1_d;
      hg1_q <= hg1_d;
      hb1_q <= hb1_d;
      s1_q  <= s1_d;
      l1_q  <= l1_d;
    end
  end

  // ---------------- stage 2: helper values q, p and spread d ----------------
  // all scaled by 10000; q in 0..10000, p = 2l - q, d = q - p
  localparam int unsigned WideW = FracW + 1;

  logic [WideW-1:0] q_lo, q_hi, q_w, p_w, d_w;
  logic [HueW-1:0]  hr2_q, hg2_q, hb2_q;
  logic [FracW-1:0] q2_q, p2_q, d2_q;

  always_comb begin
    q_lo = WideW'(l1_q) * (WideW'(s1_q) + WideW'(PctMax));
    q_hi = WideW'(PctMax) * (WideW'(l1_q) + WideW'(s1_q)) - WideW'(l1_q) * WideW'(s1_q);
    q_w  = (l1_q < PctHalf) ? q_lo : q_hi;
    p_w  = WideW'(200) * WideW'(l1_q) - q_w;
    d_w  = q_w - p_w;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hr2_q <= hr1_q;
      hg2_q <= hg1_q;
      hb2_q <= hb1_q;
      q2_q  <= q_w[FracW-1:0];
      p2_q  <= p_w[FracW-1:0];
      d2_q  <= d_w[FracW-1:0];
    end
  end

  // ---------------- stages 3 and 4: per-channel units ----------------
  hsl2rgb_stg_t stg;

  assign stg.en_num = en3;
  assign stg.en_out = en4;

  hsl2rgb_chan u_red (
    .clk_i  (clk_i),
    .stg_i  (stg),
    .hue_i  (hr2_q),
    .p_i    (p2_q),
    .q_i    (q2_q),
    .d_i    (d2_q),
    .chan_o (red_o)
  );

  hsl2rgb_chan u_green (
    .clk_i  (clk_i),
    .stg_i  (stg),
    .hue_i  (hg2_q),
    .p_i    (p2_q),
    .q_i    (q2_q),
    .d_i    (d2_q),
    .chan_o (green_o)
  );

  hsl2rgb_chan u_blue (
    .clk_i  (clk_i),
    .stg_i  (stg),
    .hue_i  (hb2_q),
    .p_i    (p2_q),
    .q_i    (q2_q),
    .d_i    (d2_q),
    .chan_o (blue_o)
  );

endmodule

// File: rtl/hsl2rgb_checker.sv
// hsl2rgb_checker: port-level assertions for hsl_to_rgb_converter_unit, with its bind.
// Depends on hsl2rgb_pkg and hsl_to_rgb_converter_unit_macros.svh.
`include "hsl_to_rgb_converter_unit_macros.svh"

module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ChanW-1:0] red_o,
  input logic [ChanW-1:0] green_o,
  input logic [ChanW-1:0] blue_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  `HSL2RGB_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")
  `HSL2RGB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o), "stalled result changed")
  `HSL2RGB_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")
  `HSL2RGB_ASSERT(a_latency, in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o, "result missing four cycles after request")

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_hsl2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

// File: tb/sv/tb_hsl_to_rgb_converter_unit.sv
// tb_hsl_to_rgb_converter_unit: self-checking testbench for the HSL to RGB converter.
// Depends on hsl2rgb_pkg and hsl_to_rgb_converter_unit; randomized traffic on both
// handshakes, every response checked against an in-bench color model.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_unit;
  import hsl2rgb_pkg::*;

  localparam int unsigned RandomReqs = 1530;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxGap     = 13;
  localparam int unsigned HoldCycles = 250;   // long output stall, fills the pipeline
  localparam int unsigned HoldEvery  = 600;   // requests between long stalls
  localparam int unsigned DrainWait  = 20;    // pipeline is four deep; margin on top

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] lit;
  } hsl_req_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_rsp_t;

  // DUT connections; every input starts at a known value
  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b1;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [HueW-1:0]  hue_degrees_i    = '0;
  logic [PctW-1:0]  saturation_pct_i = '0;
  logic [PctW-1:0]  lightness_pct_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  hsl_req_t    hsl_pending[$];   // requests not yet offered
  rgb_rsp_t    rgb_pending[$];   // predicted colors, oldest first
  int unsigned req_total = 0;
  int unsigned sent_cnt  = 0;    // requests accepted by the DUT
  int unsigned got_cnt   = 0;    // responses accepted from the DUT
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  hsl_req_t    next_req;
  rgb_rsp_t    want_rgb;
  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  bit          send_rush = 1'b0; // stretches without input idling
  bit          recv_rush = 1'b0; // stretches without output idling
  int unsigned hold_left = 0;
  int unsigned hold_mark = HoldEvery;

  hsl_to_rgb_converter_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .hue_degrees_i   (hue_degrees_i),
    .saturation_pct_i(saturation_pct_i),
    .lightness_pct_i (lightness_pct_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o)
  );

  // --------------------------------------------------------------------------
  // Color model
  // --------------------------------------------------------------------------

  // One channel as floor(N*255/600000), N = 60*p + (q-p)*dh, p and q scaled by 1e4.
  function automatic logic [ChanW-1:0] ramp_level(int unsigned p, int unsigned q,
                                                  int unsigned t);
    int unsigned n;
    if (t < Hue60)
      n = SectorDeg * p + (q - p) * t;
    else if (t < Hue180)
      n = SectorDeg * q;
    else if (t < Hue240)
      n = SectorDeg * p + (q - p) * (Hue240 - t);
    else
      n = SectorDeg * p;
    return ChanW'((n * 255) / (SectorDeg * 10000));
  endfunction

  function automatic rgb_rsp_t rgb_from_hsl(logic [HueW-1:0] hue, logic [PctW-1:0] sat,
                                            logic [PctW-1:0] lit);
    int unsigned h;
    int unsigned s;
    int unsigned l;
    int unsigned q;
    int unsigned p;
    rgb_rsp_t    c;
    h = int'(hue) % HueTurn;               // hues past a full turn wrap
    s = (sat > PctMax) ? PctMax : sat;     // percents clamp at 100
    l = (lit > PctMax) ? PctMax : lit;
    if (l < PctHalf)
      q = l * (100 + s);
    else
      q = 100 * (l + s) - l * s;
    p = 200 * l - q;                       // grey falls out with p == q
    c.red   = ramp_level(p, q, (h + Hue120) % HueTurn);
    c.green = ramp_level(p, q, h);
    c.blue  = ramp_level(p, q, (h + Hue240) % HueTurn);
    return c;
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic hsl_req_t mk_req(int unsigned h, int unsigned s, int unsigned l);
    hsl_req_t r;
    r.hue = HueW'(h);
    r.sat = PctW'(s);
    r.lit = PctW'(l);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: pops the stimulus queue, random gap before each request.
  // A new request is only loaded when the slot is empty or was just accepted,
  // so valid and payload hold steady while the DUT back-pressures.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      hue_degrees_i    <= '0;
      saturation_pct_i <= '0;
      lightness_pct_i  <= '0;
      send_gap         <= 0;
      sent_cnt         <= 0;
    end else begin
      // prediction is made at acceptance, from the payload the DUT just took
      if (in_valid_i && in_ready_o) begin
        rgb_pending.push_back(rgb_from_hsl(hue_degrees_i, saturation_pct_i,
                                           lightness_pct_i));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (hsl_pending.size() != 0) begin
          next_req = hsl_pending.pop_front();
          hue_degrees_i    <= next_req.hue;
          saturation_pct_i <= next_req.sat;
          lightness_pct_i  <= next_req.lit;
          in_valid_i       <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_rush = !send_rush;
          send_gap <= send_rush ? 0 : $urandom_range(0, MaxGap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long output hold-off, counted here; the driver keeps offering meanwhile,
  // so the pipeline fills and in_ready_o must drop.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_mark <= HoldEvery;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (sent_cnt >= hold_mark) begin
      hold_left <= HoldCycles;
      hold_mark <= hold_mark + HoldEvery;
    end
  end

  // --------------------------------------------------------------------------
  // Response ready: random stall after each accepted response.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if ($urandom_range(0, 31) == 0) recv_rush = !recv_rush;
      recv_gap    <= recv_rush ? 0 : $urandom_range(0, MaxGap);
      out_ready_i <= recv_rush && (hold_left == 0);
    end else if (recv_gap != 0) begin
      recv_gap    <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each accepted response against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_cnt <= got_cnt + 1;
      if (rgb_pending.size() == 0) begin
        log_error($sformatf("response %0d/%0d/%0d with no request pending",
                            red_o, green_o, blue_o));
      end else begin
        want_rgb = rgb_pending.pop_front();
        if (red_o !== want_rgb.red)
          log_error($sformatf("red %0d, expected %0d", red_o, want_rgb.red));
        if (green_o !== want_rgb.green)
          log_error($sformatf("green %0d, expected %0d", green_o, want_rgb.green));
        if (blue_o !== want_rgb.blue)
          log_error($sformatf("blue %0d, expected %0d", blue_o, want_rgb.blue));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // real falling edge at time zero, so the async reset clears the valid bits
    rst_ni <= 1'b0;
    // directed: primaries, sector edges, hue wrap, clamps, grey, black, white
    hsl_pending.push_back(mk_req(0, 100, 50));
    hsl_pending.push_back(mk_req(120, 100, 50));
    hsl_pending.push_back(mk_req(240, 100, 50));
    hsl_pending.push_back(mk_req(59, 100, 50));
    hsl_pending.push_back(mk_req(60, 100, 50));
    hsl_pending.push_back(mk_req(179, 100, 50));
    hsl_pending.push_back(mk_req(180, 100, 50));
    hsl_pending.push_back(mk_req(239, 100, 50));
    hsl_pending.push_back(mk_req(359, 100, 50));
    hsl_pending.push_back(mk_req(360, 100, 50));    // wraps to red
    hsl_pending.push_back(mk_req(511, 100, 50));    // widest hue code
    hsl_pending.push_back(mk_req(256, 73, 61));
    hsl_pending.push_back(mk_req(300, 0, 37));      // grey
    hsl_pending.push_back(mk_req(17, 0, 100));      // white via grey
    hsl_pending.push_back(mk_req(45, 80, 0));       // black
    hsl_pending.push_back(mk_req(0, 0, 0));
    hsl_pending.push_back(mk_req(200, 127, 127));   // both percents clamped
    hsl_pending.push_back(mk_req(90, 127, 49));     // last dark lightness
    hsl_pending.push_back(mk_req(90, 101, 50));     // first light lightness
    hsl_pending.push_back(mk_req(330, 55, 127));
    hsl_pending.push_back(mk_req(255, 64, 64));
    hsl_pending.push_back(mk_req(170, 1, 99));
    // random: mostly legal colors, some codes past the legal ranges
    for (int i = 0; i < RandomReqs; i++) begin
      if ($urandom_range(0, 99) < 85)
        hsl_pending.push_back(mk_req($urandom_range(0, 359), $urandom_range(0, 100),
                                     $urandom_range(0, 100)));
      else
        hsl_pending.push_back(mk_req($urandom_range(0, 511), $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
    end
    req_total = hsl_pending.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // counters are registered, so these waits do not race the driver or monitor
    do @(posedge clk_i); while (sent_cnt != req_total);
    do @(posedge clk_i); while (got_cnt < req_total);
    repeat (DrainWait) @(posedge clk_i);

    if (rgb_pending.size() != 0)
      log_error($sformatf("%0d predicted responses never arrived", rgb_pending.size()));

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
